/* src/mcld_pkg.sv */
// package: shared constants and types for the length-prefix deframer
package mcld_pkg;

  // number of connection contexts held in the context memory
  localparam int CONNECTIONS = 64;
  localparam int ADDR_W      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  // fixed field widths
  localparam int CONN_W = 6;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;

  // per-connection phase codes
  localparam logic [1:0] PH_HIGH    = 2'd0;
  localparam logic [1:0] PH_LOW     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // one connection context as stored in memory
  typedef struct packed {
    logic [1:0]        phase;
    logic [BYTE_W-1:0] saved_high;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  length;
  } conn_ctx_t;

  localparam int CTX_W = $bits(conn_ctx_t);

endpackage

/* src/mcld_if.sv */
// interfaces: byte request channel and frame byte result channel
interface mcld_in_if
  import mcld_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CONN_W-1:0] conn_id;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output conn_id, output data_byte, input ready);
  modport sink   (input valid, input conn_id, input data_byte, output ready);
  modport mon    (input valid, input ready, input conn_id, input data_byte);
endinterface

interface mcld_out_if
  import mcld_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CONN_W-1:0] out_conn;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              first_of_frame;
  logic              last_of_frame;
  logic              empty_frame;

  modport source (output valid, output out_conn, output out_byte, output frame_length,
                  output first_of_frame, output last_of_frame, output empty_frame,
                  input ready);
  modport sink   (input valid, input out_conn, input out_byte, input frame_length,
                  input first_of_frame, input last_of_frame, input empty_frame,
                  output ready);
  modport mon    (input valid, input ready, input out_conn, input out_byte,
                  input frame_length, input first_of_frame, input last_of_frame,
                  input empty_frame);
endinterface

/* src/mcld_ram.sv */
// generic single-write, single-read ram with registered read data
module mcld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* src/multi_connection_length_prefix_deframer_unit.sv */
// top level: per-connection length-prefix deframer over a context memory
//
// Takes one byte request per cycle, tagged with its connection, and sustains
// one byte per cycle regardless of how connections interleave, while the
// receiver takes results. Each frame is a 2-byte big-endian length followed
// by that many payload bytes; every payload byte leaves with its connection,
// the frame length and first/last marks, and a zero-length frame leaves one
// result marked empty. Length bytes give no result. A byte's result is loaded
// into the result register from the update stage: the context memory read is
// issued at the accepting edge, and the update and write back follow in the
// update stage. The context memory is read and written back once per byte;
// the last write is forwarded when the next byte hits the same connection. A
// result that waits on the receiver holds a result-giving byte in the update
// stage and stops further requests until the result leaves. Contexts start
// cleared after reset without a clearing pass (one valid bit per connection).
// A connection id at or above the connection count is taken and dropped.
module multi_connection_length_prefix_deframer_unit
  import mcld_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  mcld_in_if.sink       in_chan,
  mcld_out_if.source    out_chan
);

  // request accept
  logic in_acc;
  assign in_acc = in_chan.valid && in_chan.ready;

  // update stage registers
  logic              s1_valid_r;
  logic              s1_inr_r;
  logic [CONN_W-1:0] s1_conn_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [ADDR_W-1:0] s1_addr;

  assign s1_addr = s1_conn_r[ADDR_W-1:0];

  // last write, kept for forwarding
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  conn_ctx_t         fwd_data_r;

  logic [CONNECTIONS-1:0] ctx_vld_r;

  // result register
  logic              out_valid_r;
  logic [CONN_W-1:0] out_conn_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_first_r;
  logic              out_last_r;
  logic              out_empty_r;

  logic [CTX_W-1:0] rd_data;
  conn_ctx_t        cur;
  conn_ctx_t        ctx_nxt;
  logic             emit;
  logic [BYTE_W-1:0] res_byte;
  logic [LEN_W-1:0]  res_len;
  logic              res_first;
  logic              res_last;
  logic              res_empty;
  logic [LEN_W-1:0]  new_len;
  logic              s1_go;
  logic              wr_en;

  // context memory
  mcld_ram #(
    .WIDTH (CTX_W),
    .DEPTH (CONNECTIONS)
  ) u_ctx_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (ctx_nxt),
    .rd_en   (in_acc),
    .rd_addr (in_chan.conn_id[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // context select: forwarded write, stored entry or cleared entry
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) begin
      cur = fwd_data_r;
    end else if (ctx_vld_r[s1_addr]) begin
      cur = conn_ctx_t'(rd_data);
    end else begin
      cur = '0;
    end
  end

  // phase update and result
  always_comb begin
    ctx_nxt   = cur;
    emit      = 1'b0;
    res_byte  = s1_byte_r;
    res_len   = cur.length;
    res_first = 1'b0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    new_len   = {cur.saved_high, s1_byte_r};
    unique case (cur.phase)
      PH_LOW: begin
        ctx_nxt.length = new_len;
        if (new_len == '0) begin
          ctx_nxt.remaining = '0;
          ctx_nxt.phase     = PH_HIGH;
          emit              = 1'b1;
          res_byte          = '0;
          res_len           = '0;
          res_empty         = 1'b1;
        end else begin
          ctx_nxt.remaining = new_len;
          ctx_nxt.phase     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit      = 1'b1;
        res_first = (cur.remaining == cur.length);
        res_last  = (cur.remaining <= LEN_W'(1));
        if (res_last) begin
          ctx_nxt.remaining = '0;
          ctx_nxt.phase     = PH_HIGH;
        end else begin
          ctx_nxt.remaining = cur.remaining - LEN_W'(1);
        end
      end
      default: begin
        ctx_nxt.saved_high = s1_byte_r;
        ctx_nxt.phase      = PH_LOW;
      end
    endcase
    if (!s1_inr_r) begin
      emit = 1'b0;
    end
  end

  // stage advance and backpressure
  assign s1_go         = !emit || !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign wr_en         = s1_valid_r && s1_inr_r && s1_go;

  // update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_conn_r <= in_chan.conn_id;
      s1_byte_r <= in_chan.data_byte;
      s1_inr_r  <= (int'(in_chan.conn_id) < CONNECTIONS);
    end
  end

  // valid bits and forwarding control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_vld_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      ctx_vld_r[s1_addr] <= 1'b1;
      fwd_valid_r        <= 1'b1;
    end
  end

  // forwarding payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= ctx_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && emit && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_valid_r && emit && s1_go) begin
      out_conn_r  <= s1_conn_r;
      out_byte_r  <= res_byte;
      out_len_r   <= res_len;
      out_first_r <= res_first;
      out_last_r  <= res_last;
      out_empty_r <= res_empty;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_conn       = out_conn_r;
  assign out_chan.out_byte       = out_byte_r;
  assign out_chan.frame_length   = out_len_r;
  assign out_chan.first_of_frame = out_first_r;
  assign out_chan.last_of_frame  = out_last_r;
  assign out_chan.empty_frame    = out_empty_r;

endmodule

/* src/mcld_checker.sv */
// checker: port-level properties of the deframer, bound to the top level
module mcld_checker
  import mcld_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CONN_W-1:0] out_conn,
  input logic [BYTE_W-1:0] out_byte,
  input logic [LEN_W-1:0]  frame_length,
  input logic              first_of_frame,
  input logic              last_of_frame,
  input logic              empty_frame
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_conn) && $stable(out_byte) &&
      $stable(frame_length) && $stable(first_of_frame) &&
      $stable(last_of_frame) && $stable(empty_frame))
    else $error("result changed while stalled");

  // an empty frame carries no byte and no marks
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_frame |->
      out_byte == '0 && frame_length == '0 && !first_of_frame && !last_of_frame)
    else $error("empty frame result not clean");

  // a payload byte belongs to a frame of nonzero length
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty_frame |-> frame_length != '0)
    else $error("payload byte with zero frame length");

  // a byte both first and last closes a one-byte frame
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_of_frame && last_of_frame |-> frame_length == LEN_W'(1))
    else $error("single-byte frame with wrong length");

endmodule

bind multi_connection_length_prefix_deframer_unit mcld_checker u_mcld_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_conn       (out_chan.out_conn),
  .out_byte       (out_chan.out_byte),
  .frame_length   (out_chan.frame_length),
  .first_of_frame (out_chan.first_of_frame),
  .last_of_frame  (out_chan.last_of_frame),
  .empty_frame    (out_chan.empty_frame)
);
